// ----- design/gn3_pkg.sv -----
// Shared types, codes and constants for the 3D gradient noise block.
package gn3_pkg;

    localparam int TABLE_SIZE = 256;
    localparam int TABLE_AW   = $clog2(TABLE_SIZE);
    localparam int FRAC_BITS  = 16;
    localparam int GRAD_W     = 16;
    localparam int PERM_W     = 8;
    localparam int OUT_W      = 19;
    localparam int D_W        = 34;
    localparam int W_W        = 18;
    localparam int OUT_LIMIT  = 196608;

    localparam logic [1:0] REQ_EVAL = 2'd0;
    localparam logic [1:0] REQ_PERM = 2'd1;
    localparam logic [1:0] REQ_GRAD = 2'd2;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_HZ,
        PH_HY,
        PH_HX,
        PH_GRAD,
        PH_FADE,
        PH_LERP,
        PH_DONE
    } phase_t;

    typedef struct packed {
        phase_t     phase;
        logic [3:0] idx;
        logic       start;
        logic       wr_perm;
        logic       wr_grad;
        logic       load_out;
    } gn3_cmd_t;

    typedef struct packed {
        logic out_busy;
    } gn3_status_t;

    function automatic logic [3:0] last_idx(input phase_t ph);
        logic [3:0] r;
        r = 4'd0;
        unique case (ph)
            PH_HZ:   r = 4'd2;
            PH_HY:   r = 4'd4;
            PH_HX:   r = 4'd8;
            PH_GRAD: r = 4'd9;
            PH_FADE: r = 4'd11;
            PH_LERP: r = 4'd13;
            default: r = 4'd0;
        endcase
        return r;
    endfunction

endpackage

// ----- design/gn3_ram.sv -----
// Generic single-port RAM with registered read.
module gn3_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

// ----- design/gn3_ctrl.sv -----
// Sequencer for table loads and the phases of one noise evaluation.
module gn3_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [1:0]           req_type,
    input  gn3_pkg::gn3_status_t status,
    output gn3_pkg::gn3_cmd_t    cmd
);
    import gn3_pkg::*;

    phase_t     state_reg, state_next;
    logic [3:0] cnt_reg, cnt_next;
    logic       accept;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= PH_IDLE;
            cnt_reg   <= 4'd0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        in_stall     = (state_reg != PH_IDLE);
        accept       = in_valid && !in_stall;
        cmd.phase    = state_reg;
        cmd.idx      = cnt_reg;
        cmd.start    = 1'b0;
        cmd.wr_perm  = accept && (req_type == REQ_PERM);
        cmd.wr_grad  = accept && (req_type == REQ_GRAD);
        cmd.load_out = 1'b0;
        unique case (state_reg)
            PH_IDLE:
            begin
                cnt_next = 4'd0;
                if (accept && (req_type == REQ_EVAL))
                begin
                    cmd.start  = 1'b1;
                    state_next = PH_HZ;
                end
            end
            PH_DONE:
            begin
                if (!status.out_busy)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = PH_IDLE;
                end
            end
            default:
            begin
                if (cnt_reg == last_idx(state_reg))
                begin
                    cnt_next   = 4'd0;
                    state_next = phase_t'(state_reg + 3'd1);
                end
                else
                begin
                    cnt_next = cnt_reg + 4'd1;
                end
            end
        endcase
    end
endmodule

// ----- design/gn3_datapath.sv -----
// Hash, dot product, fade and interpolation datapath with the two tables.
module gn3_datapath (
    input  logic                                clk,
    input  logic                                rst_n,
    input  gn3_pkg::gn3_cmd_t                   cmd,
    output gn3_pkg::gn3_status_t                status,
    input  logic signed [31:0]                  x_pos,
    input  logic signed [31:0]                  y_pos,
    input  logic signed [31:0]                  z_pos,
    input  logic [7:0]                          table_index,
    input  logic [7:0]                          perm_value,
    input  logic signed [15:0]                  grad_x,
    input  logic signed [15:0]                  grad_y,
    input  logic signed [15:0]                  grad_z,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [gn3_pkg::OUT_W-1:0]    noise_value
);
    import gn3_pkg::*;

    localparam logic signed [21:0] ONE15 = 22'sd983040;
    localparam logic signed [21:0] ONE10 = 22'sd655360;
    localparam logic signed [17:0] ONE_S = 18'sd65536;

    // point
    logic [TABLE_AW-1:0] xi_reg, yi_reg, zi_reg;
    logic [15:0]         tx_reg, ty_reg, tz_reg;

    // hash chain
    logic [TABLE_AW-1:0] pz_reg [2];
    logic [TABLE_AW-1:0] py_reg [4];
    logic [TABLE_AW-1:0] px_reg [8];

    // corner values, reused as lerp accumulators
    logic signed [D_W-1:0] d_reg [8];
    logic signed [W_W-1:0] w_reg [3];

    // read tags
    logic       rd_vld_reg;
    phase_t     rd_ph_reg;
    logic [2:0] rd_idx_reg;
    logic       pr_vld_reg;
    logic [2:0] pr_idx_reg;
    logic signed [33:0] gp_reg [3];

    // fade
    logic signed [38:0] m1_reg, m4_reg;
    logic [31:0]        m2_reg, m3_reg;
    logic signed [21:0] b_reg;

    // lerp
    logic signed [52:0] lp_reg;

    logic                      out_valid_reg;
    logic signed [OUT_W-1:0]   out_reg;

    // rams
    logic [TABLE_AW-1:0]        perm_addr, grad_addr;
    logic [PERM_W-1:0]          perm_rdata;
    logic [3*GRAD_W-1:0]        grad_rdata;
    logic                       rd_issue;

    gn3_ram #(.WIDTH(PERM_W), .DEPTH(TABLE_SIZE)) u_perm (
        .clk   (clk),
        .we    (cmd.wr_perm),
        .addr  (perm_addr),
        .wdata (perm_value),
        .rdata (perm_rdata)
    );

    gn3_ram #(.WIDTH(3 * GRAD_W), .DEPTH(TABLE_SIZE)) u_grad (
        .clk   (clk),
        .we    (cmd.wr_grad),
        .addr  (grad_addr),
        .wdata ({grad_z, grad_y, grad_x}),
        .rdata (grad_rdata)
    );

    always_comb
    begin
        perm_addr = table_index;
        grad_addr = table_index;
        rd_issue  = 1'b0;
        unique case (cmd.phase)
            PH_HZ:
            begin
                perm_addr = zi_reg + TABLE_AW'(cmd.idx[0]);
                rd_issue  = (cmd.idx < 4'd2);
            end
            PH_HY:
            begin
                perm_addr = yi_reg + TABLE_AW'(cmd.idx[0]) + pz_reg[cmd.idx[1]];
                rd_issue  = (cmd.idx < 4'd4);
            end
            PH_HX:
            begin
                perm_addr = xi_reg + TABLE_AW'(cmd.idx[0]) + py_reg[cmd.idx[2:1]];
                rd_issue  = (cmd.idx < 4'd8);
            end
            PH_GRAD:
            begin
                grad_addr = px_reg[cmd.idx[2:0]];
                rd_issue  = (cmd.idx < 4'd8);
            end
            default:
            begin
                rd_issue = 1'b0;
            end
        endcase
    end

    // corner offsets t or t - 1
    logic signed [17:0] ox, oy, oz;
    always_comb
    begin
        ox = $signed({2'b00, tx_reg}) - (rd_idx_reg[0] ? ONE_S : 18'sd0);
        oy = $signed({2'b00, ty_reg}) - (rd_idx_reg[1] ? ONE_S : 18'sd0);
        oz = $signed({2'b00, tz_reg}) - (rd_idx_reg[2] ? ONE_S : 18'sd0);
    end

    logic signed [35:0] dot_sum;
    assign dot_sum = 36'(gp_reg[0]) + 36'(gp_reg[1]) + 36'(gp_reg[2]);

    // fade operand selection
    logic [1:0]         f_axis;
    logic [15:0]        ft;
    logic signed [21:0] fa;
    assign f_axis = cmd.idx[3:2];
    always_comb
    begin
        unique case (f_axis)
            2'd0:    ft = tx_reg;
            2'd1:    ft = ty_reg;
            default: ft = tz_reg;
        endcase
        fa = $signed({6'd0, ft}) * 22'sd6 - ONE15;
    end

    // lerp operand selection
    logic [2:0]            l_k;
    logic [2:0]            la, lb;
    logic signed [W_W-1:0] lw;
    logic signed [34:0]    ldiff;
    assign l_k = cmd.idx[3:1];
    always_comb
    begin
        unique case (l_k)
            3'd0:    begin la = 3'd0; lb = 3'd1; lw = w_reg[0]; end
            3'd1:    begin la = 3'd2; lb = 3'd3; lw = w_reg[0]; end
            3'd2:    begin la = 3'd4; lb = 3'd5; lw = w_reg[0]; end
            3'd3:    begin la = 3'd6; lb = 3'd7; lw = w_reg[0]; end
            3'd4:    begin la = 3'd0; lb = 3'd2; lw = w_reg[1]; end
            3'd5:    begin la = 3'd4; lb = 3'd6; lw = w_reg[1]; end
            default: begin la = 3'd0; lb = 3'd4; lw = w_reg[2]; end
        endcase
        ldiff = 35'(d_reg[lb]) - 35'(d_reg[la]);
    end

    logic signed [36:0] lsum;
    assign lsum = 37'(d_reg[la]) + lp_reg[52:16];

    logic signed [19:0] vfin;
    logic signed [OUT_W-1:0] vsat;
    always_comb
    begin
        vfin = d_reg[0][33:14];
        if (vfin > 20'sd196608)
        begin
            vsat = OUT_W'(OUT_LIMIT);
        end
        else if (vfin < -20'sd196608)
        begin
            vsat = -OUT_W'(OUT_LIMIT);
        end
        else
        begin
            vsat = vfin[OUT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_vld_reg    <= 1'b0;
            pr_vld_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            rd_vld_reg <= rd_issue;
            pr_vld_reg <= rd_vld_reg && (rd_ph_reg == PH_GRAD);
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rd_ph_reg  <= cmd.phase;
        rd_idx_reg <= cmd.idx[2:0];
        pr_idx_reg <= rd_idx_reg;

        if (cmd.start)
        begin
            xi_reg <= x_pos[FRAC_BITS +: TABLE_AW];
            yi_reg <= y_pos[FRAC_BITS +: TABLE_AW];
            zi_reg <= z_pos[FRAC_BITS +: TABLE_AW];
            tx_reg <= x_pos[FRAC_BITS-1:0];
            ty_reg <= y_pos[FRAC_BITS-1:0];
            tz_reg <= z_pos[FRAC_BITS-1:0];
        end

        if (rd_vld_reg)
        begin
            unique case (rd_ph_reg)
                PH_HZ:   pz_reg[rd_idx_reg[0]]   <= perm_rdata;
                PH_HY:   py_reg[rd_idx_reg[1:0]] <= perm_rdata;
                PH_HX:   px_reg[rd_idx_reg]      <= perm_rdata;
                default:
                begin
                    gp_reg[0] <= $signed(grad_rdata[15:0])  * ox;
                    gp_reg[1] <= $signed(grad_rdata[31:16]) * oy;
                    gp_reg[2] <= $signed(grad_rdata[47:32]) * oz;
                end
            endcase
        end

        // drop one fraction bit: Q31 to Q30
        if (pr_vld_reg)
        begin
            d_reg[pr_idx_reg] <= dot_sum[D_W:1];
        end

        if (cmd.phase == PH_FADE)
        begin
            unique case (cmd.idx[1:0])
                2'd0:
                begin
                    m1_reg <= fa * $signed({1'b0, ft});
                    m2_reg <= ft * ft;
                end
                2'd1:
                begin
                    b_reg  <= m1_reg[37:16] + ONE10;
                    m3_reg <= m2_reg[31:16] * ft;
                end
                2'd2:
                begin
                    m4_reg <= b_reg * $signed({1'b0, m3_reg[31:16]});
                end
                default:
                begin
                    w_reg[f_axis] <= m4_reg[16 +: W_W];
                end
            endcase
        end

        if (cmd.phase == PH_LERP)
        begin
            if (!cmd.idx[0])
            begin
                lp_reg <= lw * ldiff;
            end
            else
            begin
                d_reg[la] <= lsum[D_W-1:0];
            end
        end

        if (cmd.load_out)
        begin
            out_reg <= vsat;
        end
    end

    assign status.out_busy = out_valid_reg && out_stall;
    assign out_valid       = out_valid_reg;
    assign noise_value     = out_reg;
endmodule

// ----- design/gradient_noise_3d.sv -----
// An evaluate request raises out_valid after its hash, gradient, fade and lerp phases; no new
// request is taken until its result is loaded, which waits while the previous result stalls.
// The hash chain through the single-port permutation table (14 dependent reads), 8 gradient
// reads, 12 fade and 14 lerp steps on shared multipliers set the pace. Loads are accepted
// every cycle while the sequencer is idle. A finished result waits in an output register
// while the next request is taken. Reset clears control state only; tables stay undefined.
module gradient_noise_3d (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [1:0]                       req_type,
    input  logic signed [31:0]               x_pos,
    input  logic signed [31:0]               y_pos,
    input  logic signed [31:0]               z_pos,
    input  logic [7:0]                       table_index,
    input  logic [7:0]                       perm_value,
    input  logic signed [15:0]               grad_x,
    input  logic signed [15:0]               grad_y,
    input  logic signed [15:0]               grad_z,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic signed [gn3_pkg::OUT_W-1:0] noise_value
);
    import gn3_pkg::*;

    gn3_cmd_t    cmd;
    gn3_status_t status;

    gn3_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .req_type (req_type),
        .status   (status),
        .cmd      (cmd)
    );

    gn3_datapath u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .x_pos       (x_pos),
        .y_pos       (y_pos),
        .z_pos       (z_pos),
        .table_index (table_index),
        .perm_value  (perm_value),
        .grad_x      (grad_x),
        .grad_y      (grad_y),
        .grad_z      (grad_z),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .noise_value (noise_value)
    );
endmodule

// ----- dv/gradient_noise_3d_test.sv -----
// Testbench for the 3D gradient noise block: table loads, evaluations, checked results.
module gradient_noise_3d_test;
    import gn3_pkg::*;

    typedef struct packed {
        logic [1:0]         kind;
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] pz;
        logic [7:0]         slot;
        logic [7:0]         pval;
        logic signed [15:0] gx;
        logic signed [15:0] gy;
        logic signed [15:0] gz;
    } request_t;

    localparam logic [1:0] REQ_BAD = 2'd3;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    logic [1:0] req_type;
    logic signed [31:0] x_pos;
    logic signed [31:0] y_pos;
    logic signed [31:0] z_pos;
    logic [7:0] table_index;
    logic [7:0] perm_value;
    logic signed [15:0] grad_x;
    logic signed [15:0] grad_y;
    logic signed [15:0] grad_z;
    logic out_valid;
    logic out_stall;
    logic signed [OUT_W-1:0] noise_value;

    request_t pending_reqs[$];
    logic signed [OUT_W-1:0] expected_noise[$];
    logic [7:0] perm_mirror[TABLE_SIZE];
    logic signed [15:0] grad_mirror[TABLE_SIZE][3];
    int errors;
    int calm_cycles;
    bit req_taken;

    gradient_noise_3d i_dut (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .req_type(req_type), .x_pos(x_pos), .y_pos(y_pos), .z_pos(z_pos),
        .table_index(table_index), .perm_value(perm_value),
        .grad_x(grad_x), .grad_y(grad_y), .grad_z(grad_z),
        .out_valid(out_valid), .out_stall(out_stall), .noise_value(noise_value)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic longint floor_shr(input longint v, input int s);
        return v >>> s;
    endfunction

    function automatic longint fade_weight(input longint t);
        longint one;
        longint a;
        longint b;
        longint t2;
        longint t3;
        one = 64'sd1 << FRAC_BITS;
        a = 6 * t - 15 * one;
        b = floor_shr(a * t, FRAC_BITS) + 10 * one;
        t2 = floor_shr(t * t, FRAC_BITS);
        t3 = floor_shr(t2 * t, FRAC_BITS);
        return floor_shr(b * t3, FRAC_BITS);
    endfunction

    function automatic longint blend(input longint a, input longint b, input longint w);
        return a + floor_shr(w * (b - a), 16);
    endfunction

    function automatic longint corner_dot(input longint cx, input longint cy,
                                          input longint cz, input longint ox,
                                          input longint oy, input longint oz);
        logic [7:0] g;
        longint d;
        g = perm_mirror[8'(cx + perm_mirror[8'(cy + perm_mirror[8'(cz)])])];
        d = longint'(grad_mirror[g][0]) * ox + longint'(grad_mirror[g][1]) * oy
          + longint'(grad_mirror[g][2]) * oz;
        return floor_shr(d, 15 + FRAC_BITS - 30);
    endfunction

    function automatic logic signed [OUT_W-1:0] noise_at(input request_t r);
        longint one;
        longint fx, fy, fz, tx, ty, tz, ux, uy, uz;
        longint d[8];
        longint wx, wy, wz, v;
        one = 64'sd1 << FRAC_BITS;
        fx = floor_shr(longint'(r.px), FRAC_BITS);
        fy = floor_shr(longint'(r.py), FRAC_BITS);
        fz = floor_shr(longint'(r.pz), FRAC_BITS);
        tx = r.px - fx * one;
        ty = r.py - fy * one;
        tz = r.pz - fz * one;
        ux = tx - one;
        uy = ty - one;
        uz = tz - one;
        d[0] = corner_dot(fx, fy, fz, tx, ty, tz);
        d[1] = corner_dot(fx + 1, fy, fz, ux, ty, tz);
        d[2] = corner_dot(fx, fy + 1, fz, tx, uy, tz);
        d[3] = corner_dot(fx + 1, fy + 1, fz, ux, uy, tz);
        d[4] = corner_dot(fx, fy, fz + 1, tx, ty, uz);
        d[5] = corner_dot(fx + 1, fy, fz + 1, ux, ty, uz);
        d[6] = corner_dot(fx, fy + 1, fz + 1, tx, uy, uz);
        d[7] = corner_dot(fx + 1, fy + 1, fz + 1, ux, uy, uz);
        wx = fade_weight(tx);
        wy = fade_weight(ty);
        wz = fade_weight(tz);
        v = blend(blend(blend(d[0], d[1], wx), blend(d[2], d[3], wx), wy),
                  blend(blend(d[4], d[5], wx), blend(d[6], d[7], wx), wy), wz);
        v = floor_shr(v, 14);
        if (v > OUT_LIMIT) v = OUT_LIMIT;
        if (v < -OUT_LIMIT) v = -OUT_LIMIT;
        return OUT_W'(v);
    endfunction

    function automatic request_t eval_req(input logic [31:0] x, input logic [31:0] y,
                                          input logic [31:0] z);
        request_t r;
        r = '0;
        r.kind = REQ_EVAL;
        r.px = x;
        r.py = y;
        r.pz = z;
        r.slot = 8'($urandom);
        r.pval = 8'($urandom);
        return r;
    endfunction

    // Permutation values stay below 64, so only gradient entries 0 to 63 are ever read.
    function automatic request_t load_req(input logic [1:0] k, input logic [7:0] s);
        request_t r;
        r.kind = k;
        r.px = $urandom;
        r.py = $urandom;
        r.pz = $urandom;
        r.slot = s;
        r.pval = 8'($urandom_range(0, 63));
        r.gx = 16'($urandom);
        r.gy = 16'($urandom);
        r.gz = 16'($urandom);
        return r;
    endfunction

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 4))
            0: return 32'h8000_0000 + $urandom_range(0, 3);
            1: return 32'h7fff_ffff - $urandom_range(0, 3);
            2: return {{16{1'b0}}, 16'($urandom)} - 32'h0000_8000;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic signed [15:0] rand_grad();
        case ($urandom_range(0, 5))
            0: return 16'sh8000;
            1: return 16'sh7fff;
            default: return 16'($urandom);
        endcase
    endfunction

    // Driver: present the next request at the falling edge; hold it while stalled.
    always @(negedge clk)
    begin
        if (rst_n && (!in_valid || req_taken))
        begin
            if (in_valid)
                void'(pending_reqs.pop_front());
            if (pending_reqs.size() > 0 && (calm_cycles > 0 || $urandom_range(0, 99) >= 32))
            begin
                in_valid    <= 1'b1;
                req_type    <= pending_reqs[0].kind;
                x_pos       <= pending_reqs[0].px;
                y_pos       <= pending_reqs[0].py;
                z_pos       <= pending_reqs[0].pz;
                table_index <= pending_reqs[0].slot;
                perm_value  <= pending_reqs[0].pval;
                grad_x      <= pending_reqs[0].gx;
                grad_y      <= pending_reqs[0].gy;
                grad_z      <= pending_reqs[0].gz;
            end
            else
                in_valid <= 1'b0;
        end
        out_stall <= (calm_cycles == 0) && ($urandom_range(0, 99) < 32);
        if (calm_cycles > 0)
            calm_cycles <= calm_cycles - 1;
        else if ($urandom_range(0, 2999) == 0)
            calm_cycles <= 600;
    end

    // Monitor: predict on every accepted request, check every accepted result.
    always @(posedge clk)
    begin
        request_t r;
        req_taken = rst_n && in_valid && !in_stall;
        if (req_taken)
        begin
            r = pending_reqs[0];
            case (r.kind)
                REQ_PERM: perm_mirror[r.slot] = r.pval;
                REQ_GRAD:
                begin
                    grad_mirror[r.slot][0] = r.gx;
                    grad_mirror[r.slot][1] = r.gy;
                    grad_mirror[r.slot][2] = r.gz;
                end
                REQ_EVAL: expected_noise.push_back(noise_at(r));
                default: ;
            endcase
        end
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_noise.size() == 0)
            begin
                $display("%0t: unexpected noise_value %0d", $time, noise_value);
                errors++;
            end
            else
            begin
                if (noise_value !== expected_noise[0])
                begin
                    $display("%0t: noise_value expected %0d actual %0d",
                             $time, expected_noise[0], noise_value);
                    errors++;
                end
                void'(expected_noise.pop_front());
            end
        end
    end

    initial
    begin
        errors = 0;
        calm_cycles = 0;
        req_taken = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        out_stall = 1'b0;
        req_type = REQ_EVAL;
        {x_pos, y_pos, z_pos} = '0;
        {table_index, perm_value} = '0;
        {grad_x, grad_y, grad_z} = '0;
        // Load the whole permutation table and every gradient entry its values can reach.
        for (int i = 0; i < TABLE_SIZE; i++)
        begin
            pending_reqs.push_back(load_req(REQ_PERM, 8'(i)));
            if (i < 64)
                pending_reqs.push_back(load_req(REQ_GRAD, 8'(i)));
        end
        pending_reqs[1].gx = 16'sh7fff;
        pending_reqs[1].gy = 16'sh7fff;
        pending_reqs[1].gz = 16'sh7fff;
        pending_reqs[3].gx = 16'sh8000;
        pending_reqs[3].gy = 16'sh8000;
        pending_reqs[3].gz = 16'sh8000;
        // Directed points: zero, lattice points, extremes, just below integers.
        pending_reqs.push_back(eval_req(0, 0, 0));
        pending_reqs.push_back(eval_req(32'h0001_0000, 32'h0002_0000, 32'h0003_0000));
        pending_reqs.push_back(eval_req(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff));
        pending_reqs.push_back(eval_req(32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
        pending_reqs.push_back(eval_req(32'hffff_ffff, 32'h0000_ffff, 32'h0000_8000));
        pending_reqs.push_back(eval_req(32'h0000_8000, 32'h0000_8000, 32'h0000_8000));
        pending_reqs.push_back(eval_req(32'hffff_8000, 32'h00ff_4000, 32'hff00_c000));
        pending_reqs.push_back(load_req(REQ_BAD, 8'hff));
        pending_reqs.push_back(eval_req(32'h0000_ffff, 32'hffff_0001, 32'h7fff_0000));
        // Random mix: mostly evaluations, with table rewrites and ignored requests.
        while (pending_reqs.size() < 550)
        begin
            case ($urandom_range(0, 9))
                0: pending_reqs.push_back(load_req(REQ_PERM, 8'($urandom)));
                1:
                begin
                    pending_reqs.push_back(load_req(REQ_GRAD, 8'($urandom)));
                    pending_reqs[$].gx = rand_grad();
                    pending_reqs[$].gy = rand_grad();
                    pending_reqs[$].gz = rand_grad();
                end
                2: pending_reqs.push_back(load_req(REQ_BAD, 8'($urandom)));
                default:
                begin
                    pending_reqs.push_back(eval_req(rand_coord(), rand_coord(), rand_coord()));
                end
            endcase
        end
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        wait (pending_reqs.size() == 0);
        wait (expected_noise.size() == 0);
        repeat (100) @(posedge clk);
        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial
    begin
        #3000000;
        $display("simulation failed");
        $finish;
    end
endmodule

// ----- gradient_noise_3d.f -----
design/gn3_pkg.sv
design/gn3_ram.sv
design/gn3_ctrl.sv
design/gn3_datapath.sv
design/gradient_noise_3d.sv
dv/gradient_noise_3d_test.sv
